/* rtl/assert_macros.svh */
// Concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define CFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cfa_pkg.sv */
package cfa_pkg;

   localparam int DATA_W        = 32;
   localparam int DIR_FRAC_BITS = 30;
   localparam int PROD_W        = 2 * DATA_W;
   localparam int XACC_W        = PROD_W + 1;
   localparam int RED_W         = XACC_W + 1 - DIR_FRAC_BITS;
   localparam int ROOT_W        = DATA_W;
   localparam int NUM_W         = DATA_W + DIR_FRAC_BITS;
   localparam int QUO_W         = DIR_FRAC_BITS + 1;
   localparam int ROOT_CNT_W    = $clog2(ROOT_W);
   localparam int QUO_CNT_W     = $clog2(QUO_W);

   localparam logic [1:0] MODE_WALK = 2'd0;
   localparam logic [1:0] MODE_LOAD = 2'd1;
   localparam logic [1:0] MODE_FLIP = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic [1:0] SEL_POS   = 2'd0;
   localparam logic [1:0] SEL_TAN   = 2'd1;
   localparam logic [1:0] SEL_NORM1 = 2'd2;
   localparam logic [1:0] SEL_NORM2 = 2'd3;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [1:0] vector_select;
      word_type   coef_0;
      word_type   coef_1;
      word_type   coef_2;
      word_type   coef_3;
      word_type   coef_4;
      word_type   coef_5;
      word_type   coef_6;
      word_type   coef_7;
      word_type   coef_8;
   } req_type;

   typedef struct packed {
      word_type pos_x;
      word_type pos_y;
      word_type pos_z;
      word_type tan_x;
      word_type tan_y;
      word_type tan_z;
      word_type norm1_x;
      word_type norm1_y;
      word_type norm1_z;
      word_type norm2_x;
      word_type norm2_y;
      word_type norm2_z;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [ROOT_W-1:0] den;
   } div_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WMUL,
      ST_WACC,
      ST_SMUL,
      ST_SACC,
      ST_RGO,
      ST_RWAIT,
      ST_DGO,
      ST_DWAIT,
      ST_NDONE,
      ST_XMUL,
      ST_XACC,
      ST_FLIP,
      ST_FINISH
   } state_type;

   function automatic logic [1:0] inc3(input logic [1:0] i);
      inc3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
   endfunction

   function automatic logic [1:0] nx2(input logic [1:0] i);
      nx2 = inc3(inc3(i));
   endfunction

   // round half up, then floor shift
   function automatic logic signed [RED_W-1:0] reduce_q(input logic signed [XACC_W-1:0] x);
      logic signed [XACC_W:0] t;
      t = $signed({x[XACC_W-1], x})
          + $signed({{(XACC_W+1-DIR_FRAC_BITS){1'b0}}, 1'b1, {(DIR_FRAC_BITS-1){1'b0}}});
      reduce_q = t[XACC_W:DIR_FRAC_BITS];
   endfunction

   function automatic word_type sat_word(input logic signed [RED_W-1:0] x);
      if ((&x[RED_W-1:DATA_W-1]) || !(|x[RED_W-1:DATA_W-1])) begin
         sat_word = x[DATA_W-1:0];
      end else begin
         sat_word = x[RED_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

   function automatic word_type neg_sat(input word_type v);
      if (v == {1'b1, {(DATA_W-1){1'b0}}}) begin
         neg_sat = {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         neg_sat = -v;
      end
   endfunction

endpackage

/* rtl/cfa_mul.sv */
module cfa_mul (
   input  logic                               clock,
   input  cfa_pkg::word_type                  mul_a,
   input  cfa_pkg::word_type                  mul_b,
   output logic signed [cfa_pkg::PROD_W-1:0]  prod
);

   logic signed [cfa_pkg::PROD_W-1:0] prod_ff;
   logic signed [cfa_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* rtl/cfa_sqrt.sv */
module cfa_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  cfa_pkg::sqrt_req_type        sq_req,
   output logic                         sq_done,
   output logic [cfa_pkg::ROOT_W-1:0]   sq_root
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [cfa_pkg::ROOT_CNT_W-1:0]    idx_ff, idx_in;
   logic [cfa_pkg::PROD_W-1:0]        x_ff, x_in;
   logic [cfa_pkg::PROD_W-1:0]        res_ff, res_in;
   logic [cfa_pkg::PROD_W-1:0]        bit_w;
   logic [cfa_pkg::PROD_W-1:0]        trial;

   assign bit_w   = cfa_pkg::PROD_W'(1) << {idx_ff, 1'b0};
   assign trial   = res_ff + bit_w;
   assign sq_done = done_ff;
   assign sq_root = res_ff[cfa_pkg::ROOT_W-1:0];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      idx_in  = idx_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      if (sq_req.start) begin
         busy_in = 1'b1;
         idx_in  = cfa_pkg::ROOT_CNT_W'(cfa_pkg::ROOT_W - 1);
         x_in    = sq_req.radicand;
         res_in  = '0;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_w;
         end else begin
            res_in = res_ff >> 1;
         end
         idx_in = idx_ff - 1'b1;
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      res_ff <= res_in;
   end

endmodule

/* rtl/cfa_div.sv */
module cfa_div (
   input  logic                        clock,
   input  logic                        reset,
   input  cfa_pkg::div_req_type        div_req,
   output logic                        div_done,
   output logic [cfa_pkg::QUO_W-1:0]   div_quo
);

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [cfa_pkg::QUO_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [cfa_pkg::ROOT_W-1:0]       rem_ff, rem_in;
   logic [cfa_pkg::ROOT_W-1:0]       den_ff, den_in;
   logic [cfa_pkg::QUO_W-1:0]        low_ff, low_in;
   logic [cfa_pkg::QUO_W-1:0]        quo_ff, quo_in;
   logic [cfa_pkg::ROOT_W:0]         rem2;
   logic                             take;

   assign rem2     = {rem_ff, low_ff[cfa_pkg::QUO_W-1]};
   assign take     = rem2 >= {1'b0, den_ff};
   assign div_done = done_ff;
   assign div_quo  = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = cfa_pkg::QUO_CNT_W'(cfa_pkg::QUO_W - 1);
         rem_in  = cfa_pkg::ROOT_W'(div_req.num[cfa_pkg::NUM_W-1:cfa_pkg::QUO_W]);
         low_in  = div_req.num[cfa_pkg::QUO_W-1:0];
         den_in  = div_req.den;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = take ? cfa_pkg::ROOT_W'(rem2 - {1'b0, den_ff})
                       : rem2[cfa_pkg::ROOT_W-1:0];
         low_in = low_ff << 1;
         quo_in = {quo_ff[cfa_pkg::QUO_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

endmodule

/* rtl/curve_frame_advance.sv */
// Moving frame step for a curve. A walk transaction runs from the accepting cycle to the
// result register through the nine weighted sums on the shared 32x32 multiplier, then two
// normalizations (sum of squares, a 32-step bit-serial square root and three 31-step
// bit-serial divisions with their handshakes), plus two cross products; a zero-length
// vector skips its divisions. A load or an unused mode goes straight to the result register.
// A new result waits while a stalled one is still held. req_stall stays high while a
// transaction is in work; a finished result sits in the rsp register and the next
// transaction may be taken meanwhile.
module curve_frame_advance (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfa_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfa_pkg::rsp_type  rsp_data
);

   cfa_pkg::state_type state_ff, state_in;

   cfa_pkg::word_type pos_ff[3], pos_in[3];
   cfa_pkg::word_type tan_ff[3], tan_in[3];
   cfa_pkg::word_type n1_ff[3],  n1_in[3];
   cfa_pkg::word_type n2_ff[3],  n2_in[3];
   cfa_pkg::word_type wv_ff[3],  wv_in[3];
   cfa_pkg::word_type nn2_ff[3], nn2_in[3];
   cfa_pkg::word_type coef_ff[3][3], coef_in[3][3];
   cfa_pkg::word_type xa[3], xb[3];

   logic [1:0] comp_ff, comp_in;
   logic [1:0] grp_ff,  grp_in;
   logic [1:0] sub_ff,  sub_in;
   logic       pass_ff, pass_in;
   logic       flip_ff, flip_in;
   logic       rsp_valid_ff, rsp_valid_in;
   cfa_pkg::rsp_type rsp_ff, rsp_in;

   logic signed [cfa_pkg::RED_W-1:0]  acc_ff, acc_in;
   logic signed [cfa_pkg::XACC_W-1:0] xacc_ff, xacc_in;
   logic [cfa_pkg::PROD_W-1:0]        sumsq_ff, sumsq_in;

   cfa_pkg::word_type                 mul_a, mul_b;
   logic signed [cfa_pkg::PROD_W-1:0] prod;
   logic signed [cfa_pkg::XACC_W-1:0] prod_x;
   logic signed [cfa_pkg::RED_W-1:0]  red, wsum;
   cfa_pkg::sqrt_req_type             sq_req;
   cfa_pkg::div_req_type              div_req;
   logic                              sq_done, div_done;
   logic [cfa_pkg::ROOT_W-1:0]        sq_root;
   logic [cfa_pkg::QUO_W-1:0]         div_quo;
   logic [cfa_pkg::DATA_W-1:0]        mag;
   logic                              accept, rsp_load;
   logic                              last_w, last_x;

   cfa_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   cfa_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .sq_req  (sq_req),
      .sq_done (sq_done),
      .sq_root (sq_root)
   );

   cfa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   assign req_stall = (state_ff != cfa_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_load  = (state_ff == cfa_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);
   assign last_w    = (comp_ff == 2'd2) && (grp_ff == 2'd2) && (sub_ff == 2'd2);
   assign last_x    = (comp_ff == 2'd2) && (sub_ff == 2'd1);
   assign prod_x    = {prod[cfa_pkg::PROD_W-1], prod};
   assign red       = cfa_pkg::reduce_q(prod_x);
   assign wsum      = ((sub_ff == 2'd0) ? '0 : acc_ff) + red;
   assign mag       = wv_ff[comp_ff][cfa_pkg::DATA_W-1] ? -wv_ff[comp_ff] : wv_ff[comp_ff];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         xa[i] = pass_ff ? tan_ff[i] : n2_ff[i];
         xb[i] = pass_ff ? n1_ff[i]  : tan_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.mode inside {cfa_pkg::MODE_WALK, cfa_pkg::MODE_FLIP}) begin
                  state_in = cfa_pkg::ST_WMUL;
               end else begin
                  state_in = cfa_pkg::ST_FINISH;
               end
            end
         end
         cfa_pkg::ST_WMUL:  state_in = cfa_pkg::ST_WACC;
         cfa_pkg::ST_WACC:  state_in = last_w ? cfa_pkg::ST_SMUL : cfa_pkg::ST_WMUL;
         cfa_pkg::ST_SMUL:  state_in = cfa_pkg::ST_SACC;
         cfa_pkg::ST_SACC:  state_in = (comp_ff == 2'd2) ? cfa_pkg::ST_RGO : cfa_pkg::ST_SMUL;
         cfa_pkg::ST_RGO:   state_in = cfa_pkg::ST_RWAIT;
         cfa_pkg::ST_RWAIT: begin
            if (sq_done) begin
               state_in = (sq_root == '0) ? cfa_pkg::ST_NDONE : cfa_pkg::ST_DGO;
            end
         end
         cfa_pkg::ST_DGO:   state_in = cfa_pkg::ST_DWAIT;
         cfa_pkg::ST_DWAIT: begin
            if (div_done) begin
               state_in = (comp_ff == 2'd2) ? cfa_pkg::ST_NDONE : cfa_pkg::ST_DGO;
            end
         end
         cfa_pkg::ST_NDONE: state_in = cfa_pkg::ST_XMUL;
         cfa_pkg::ST_XMUL:  state_in = cfa_pkg::ST_XACC;
         cfa_pkg::ST_XACC: begin
            if (last_x) begin
               if (!pass_ff) begin
                  state_in = cfa_pkg::ST_SMUL;
               end else begin
                  state_in = flip_ff ? cfa_pkg::ST_FLIP : cfa_pkg::ST_FINISH;
               end
            end else begin
               state_in = cfa_pkg::ST_XMUL;
            end
         end
         cfa_pkg::ST_FLIP:   state_in = cfa_pkg::ST_FINISH;
         cfa_pkg::ST_FINISH: state_in = rsp_load ? cfa_pkg::ST_IDLE : cfa_pkg::ST_FINISH;
         default:            state_in = cfa_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pos_in       = pos_ff;
      tan_in       = tan_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      wv_in        = wv_ff;
      nn2_in       = nn2_ff;
      coef_in      = coef_ff;
      comp_in      = comp_ff;
      grp_in       = grp_ff;
      sub_in       = sub_ff;
      pass_in      = pass_ff;
      flip_in      = flip_ff;
      acc_in       = acc_ff;
      xacc_in      = xacc_ff;
      sumsq_in     = sumsq_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mul_a        = coef_ff[grp_ff][sub_ff];
      mul_b        = tan_ff[comp_ff];
      sq_req       = '{start: 1'b0, radicand: sumsq_ff};
      div_req      = '{start: 1'b0,
                       num: {mag, {cfa_pkg::DIR_FRAC_BITS{1'b0}}}
                            + cfa_pkg::NUM_W'(sq_root[cfa_pkg::ROOT_W-1:1]),
                       den: sq_root};

      case (state_ff)
         cfa_pkg::ST_IDLE: begin
            comp_in = 2'd0;
            grp_in  = 2'd0;
            sub_in  = 2'd0;
            pass_in = 1'b0;
            if (accept) begin
               flip_in       = (req_data.mode == cfa_pkg::MODE_FLIP);
               coef_in[0][0] = req_data.coef_0;
               coef_in[0][1] = req_data.coef_1;
               coef_in[0][2] = req_data.coef_2;
               coef_in[1][0] = req_data.coef_3;
               coef_in[1][1] = req_data.coef_4;
               coef_in[1][2] = req_data.coef_5;
               coef_in[2][0] = req_data.coef_6;
               coef_in[2][1] = req_data.coef_7;
               coef_in[2][2] = req_data.coef_8;
               if (req_data.mode == cfa_pkg::MODE_LOAD) begin
                  case (req_data.vector_select)
                     cfa_pkg::SEL_POS:   pos_in = '{req_data.coef_0, req_data.coef_1,
                                                    req_data.coef_2};
                     cfa_pkg::SEL_TAN:   tan_in = '{req_data.coef_0, req_data.coef_1,
                                                    req_data.coef_2};
                     cfa_pkg::SEL_NORM1: n1_in  = '{req_data.coef_0, req_data.coef_1,
                                                    req_data.coef_2};
                     default:            n2_in  = '{req_data.coef_0, req_data.coef_1,
                                                    req_data.coef_2};
                  endcase
               end
            end
         end
         cfa_pkg::ST_WMUL: begin
            case (sub_ff)
               2'd0:    mul_b = tan_ff[comp_ff];
               2'd1:    mul_b = n1_ff[comp_ff];
               default: mul_b = n2_ff[comp_ff];
            endcase
         end
         cfa_pkg::ST_WACC: begin
            acc_in = wsum;
            if (sub_ff == 2'd2) begin
               case (grp_ff)
                  2'd0:    pos_in[comp_ff] = cfa_pkg::sat_word(wsum
                              + cfa_pkg::RED_W'(pos_ff[comp_ff]));
                  2'd1:    wv_in[comp_ff]  = cfa_pkg::sat_word(wsum);
                  default: nn2_in[comp_ff] = cfa_pkg::sat_word(wsum);
               endcase
               sub_in = 2'd0;
               grp_in = cfa_pkg::inc3(grp_ff);
               if (grp_ff == 2'd2) begin
                  comp_in = cfa_pkg::inc3(comp_ff);
               end
            end else begin
               sub_in = sub_ff + 2'd1;
            end
         end
         cfa_pkg::ST_SMUL: begin
            mul_a = wv_ff[comp_ff];
            mul_b = wv_ff[comp_ff];
         end
         cfa_pkg::ST_SACC: begin
            sumsq_in = ((comp_ff == 2'd0) ? '0 : sumsq_ff) + prod;
            comp_in  = cfa_pkg::inc3(comp_ff);
         end
         cfa_pkg::ST_RGO: begin
            sq_req.start = 1'b1;
         end
         cfa_pkg::ST_DGO: begin
            div_req.start = 1'b1;
         end
         cfa_pkg::ST_DWAIT: begin
            if (div_done) begin
               wv_in[comp_ff] = wv_ff[comp_ff][cfa_pkg::DATA_W-1]
                                ? -cfa_pkg::DATA_W'(div_quo) : cfa_pkg::DATA_W'(div_quo);
               comp_in = cfa_pkg::inc3(comp_ff);
            end
         end
         cfa_pkg::ST_NDONE: begin
            comp_in = 2'd0;
            sub_in  = 2'd0;
            if (!pass_ff) begin
               tan_in = wv_ff;
               n2_in  = nn2_ff;
            end else begin
               n1_in = wv_ff;
            end
         end
         cfa_pkg::ST_XMUL: begin
            if (sub_ff == 2'd0) begin
               mul_a = xa[cfa_pkg::inc3(comp_ff)];
               mul_b = xb[cfa_pkg::nx2(comp_ff)];
            end else begin
               mul_a = xa[cfa_pkg::nx2(comp_ff)];
               mul_b = xb[cfa_pkg::inc3(comp_ff)];
            end
         end
         cfa_pkg::ST_XACC: begin
            if (sub_ff == 2'd0) begin
               xacc_in = prod_x;
               sub_in  = 2'd1;
            end else begin
               if (!pass_ff) begin
                  wv_in[comp_ff] = cfa_pkg::sat_word(cfa_pkg::reduce_q(xacc_ff - prod_x));
               end else begin
                  n2_in[comp_ff] = cfa_pkg::sat_word(cfa_pkg::reduce_q(xacc_ff - prod_x));
               end
               sub_in  = 2'd0;
               comp_in = cfa_pkg::inc3(comp_ff);
               if (last_x) begin
                  pass_in = 1'b1;
               end
            end
         end
         cfa_pkg::ST_FLIP: begin
            for (int i = 0; i < 3; i++) begin
               tan_in[i] = cfa_pkg::neg_sat(tan_ff[i]);
               n1_in[i]  = cfa_pkg::neg_sat(n1_ff[i]);
            end
         end
         cfa_pkg::ST_FINISH: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{pos_x: pos_ff[0], pos_y: pos_ff[1], pos_z: pos_ff[2],
                          tan_x: tan_ff[0], tan_y: tan_ff[1], tan_z: tan_ff[2],
                          norm1_x: n1_ff[0], norm1_y: n1_ff[1], norm1_z: n1_ff[2],
                          norm2_x: n2_ff[0], norm2_y: n2_ff[1], norm2_z: n2_ff[2]};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfa_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         comp_ff      <= 2'd0;
         grp_ff       <= 2'd0;
         sub_ff       <= 2'd0;
         pass_ff      <= 1'b0;
         flip_ff      <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            tan_ff[i] <= '0;
            n1_ff[i]  <= '0;
            n2_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         comp_ff      <= comp_in;
         grp_ff       <= grp_in;
         sub_ff       <= sub_in;
         pass_ff      <= pass_in;
         flip_ff      <= flip_in;
         pos_ff       <= pos_in;
         tan_ff       <= tan_in;
         n1_ff        <= n1_in;
         n2_ff        <= n2_in;
      end
   end

   always_ff @(posedge clock) begin
      wv_ff    <= wv_in;
      nn2_ff   <= nn2_in;
      coef_ff  <= coef_in;
      acc_ff   <= acc_in;
      xacc_ff  <= xacc_in;
      sumsq_ff <= sumsq_in;
      rsp_ff   <= rsp_in;
   end

endmodule

/* rtl/cfa_checker.sv */
`include "assert_macros.svh"

module cfa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cfa_pkg::rsp_type rsp_data
);

   `CFA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "rsp dropped")
   `CFA_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_data), "rsp changed")
   `CFA_ASSERT(a_busy, clock, reset, req_valid && !req_stall |=> req_stall, "not busy after transaction")
   `CFA_ASSERT(a_rsp_busy, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "rsp without work")
   `CFA_ASSERT_ALWAYS(a_reset, clock, reset |=> !rsp_valid, "rsp valid after reset")

endmodule

bind curve_frame_advance cfa_checker u_cfa_checker (.*);
